// ===== rtl/bsb_pkg.sv =====
// ----------------------------------------------------------------------------
// bsb_pkg
// Shared types and constants for the bit map store with square brush writes.
// ----------------------------------------------------------------------------
package bsb_pkg;

    // Map geometry.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);

    // Bit store organization: wide words, one read-modify-write per word.
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int MEM_DEPTH  = CELL_COUNT / WORD_BITS;
    localparam int MEM_AW     = ADDR_W - BIT_W;

    // Field widths fixed by the interface.
    localparam int DIM_W      = 9;
    localparam int COORD_W    = 16;
    localparam int AREA_W     = 16;
    localparam int ROOT_W     = AREA_W / 2;
    localparam int HALF_W     = ROOT_W - 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_READ_DIRECT  = 2'd0,
        OP_READ_SHIFTED = 2'd1,
        OP_SET_SQUARE   = 2'd2,
        OP_CLEAR_SQUARE = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH  = 2'd0,
        CFG_MAP_HEIGHT = 2'd1,
        CFG_OFFSET_X   = 2'd2,
        CFG_OFFSET_Y   = 2'd3
    } t_cfg_index;

endpackage

// ===== rtl/bsb_isqrt.sv =====
// ----------------------------------------------------------------------------
// bsb_isqrt
// Digit-by-digit integer square root, one result bit per clock cycle.
// ----------------------------------------------------------------------------
module bsb_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bsb_pkg::AREA_W-1:0] i_radicand,
    output logic                       o_done,
    output logic [bsb_pkg::ROOT_W-1:0] o_root
);
    import bsb_pkg::*;

    localparam logic [AREA_W-1:0] BIT_INIT = {2'b01, {(AREA_W-2){1'b0}}};

    logic              r_run;
    logic              r_done;
    logic [AREA_W-1:0] r_rem;
    logic [AREA_W-1:0] r_res;
    logic [AREA_W-1:0] r_bit;
    logic [AREA_W:0]   trial;
    logic              fits;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};
    assign fits  = {1'b0, r_rem} >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_bit[0]) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_radicand;
            r_res <= '0;
            r_bit <= BIT_INIT;
        end else if (r_run) begin
            if (fits) begin
                r_rem <= r_rem - trial[AREA_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

// ===== rtl/bitmap_square_brush_store.sv =====
// ----------------------------------------------------------------------------
// bitmap_square_brush_store
// Bit map with point reads and clipped square brush set and clear.
// ----------------------------------------------------------------------------
// A command word is taken at a rising edge where start is high and busy is
// low. Opcodes 0 and 1 read one cell, directly or after subtracting the
// configured offsets; the bit comes back on o_bit_value with o_valid high for
// exactly one cycle, after the states S_RD_PT, S_RD_REQ and S_RD_DAT. The
// receiver cannot stall this output, and busy has already dropped in that
// cycle, so the next command may be taken at the edge that ends the result
// cycle. Opcodes 2 and 3 set or clear a square of half-side floor(isqrt(area))/2
// clipped to the map and give no result word. A brush keeps busy high through
// the square root, the clipping step, and then per map row a row step plus a
// read and a write-back for each 64-bit memory word the row touches; the
// largest square has 255 rows that each touch at most 5 words. The bit store
// is one single-port-write memory of 1024 words by 64 bits with a registered
// read. After reset, busy stays high while a clearing pass zeroes every word;
// configuration writes are taken at any time through i_cfg_we.
// ----------------------------------------------------------------------------
module bitmap_square_brush_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_opcode,
    input  logic [bsb_pkg::COORD_W-1:0]    i_pos_x,
    input  logic [bsb_pkg::COORD_W-1:0]    i_pos_y,
    input  logic [bsb_pkg::AREA_W-1:0]     i_brush_area,
    output logic                           o_valid,
    output logic                           o_bit_value,
    input  logic                           i_cfg_we,
    input  logic [bsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bsb_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_PT, S_RD_REQ, S_RD_DAT,
        S_SQRT, S_CLIP, S_ROW, S_WRD, S_WWR
    } t_state;

    localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);

    // Configuration registers.
    logic [DIM_W-1:0]   r_map_width;
    logic [DIM_W-1:0]   r_map_height;
    logic [COORD_W-1:0] r_offset_x;
    logic [COORD_W-1:0] r_offset_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= MAX_W_D;
            r_map_height <= MAX_H_D;
            r_offset_x   <= '0;
            r_offset_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data[DIM_W-1:0];
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_data[DIM_W-1:0];
                CFG_OFFSET_X:   r_offset_x   <= i_cfg_data;
                CFG_OFFSET_Y:   r_offset_y   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Out-of-range dimensions are clamped to 1..maximum.
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;

    always_comb begin
        priority if (r_map_width == '0) eff_w = DIM_W'(1);
        else if (r_map_width > MAX_W_D) eff_w = MAX_W_D;
        else eff_w = r_map_width;
        priority if (r_map_height == '0) eff_h = DIM_W'(1);
        else if (r_map_height > MAX_H_D) eff_h = MAX_H_D;
        else eff_h = r_map_height;
    end

    // Control and datapath registers.
    t_state              r_state;
    logic [MEM_AW-1:0]   r_clr;
    logic                r_valid;
    logic                r_bit_value;
    t_opcode             r_op;
    logic [COORD_W-1:0]  r_pos_x;
    logic [COORD_W-1:0]  r_pos_y;
    logic [X_W-1:0]      r_px;
    logic [Y_W-1:0]      r_py;
    logic                r_inmap;
    logic [BIT_W-1:0]    r_bitsel;
    logic [X_W-1:0]      r_lx;
    logic [X_W-1:0]      r_rx;
    logic [Y_W-1:0]      r_by;
    logic [Y_W-1:0]      r_cur_y;
    logic                r_empty;
    logic [ADDR_W-1:0]   r_start_a;
    logic [ADDR_W-1:0]   r_end_a;
    logic [MEM_AW-1:0]   r_word;

    // Bit store.
    logic [WORD_BITS-1:0] mem [MEM_DEPTH];
    logic [WORD_BITS-1:0] r_mem_q;
    logic                 mem_we;
    logic [MEM_AW-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [MEM_AW-1:0]    mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_raddr];
    end

    // Square root of the brush area.
    logic              sqrt_start;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic              accept;

    assign accept     = start && !busy;
    assign sqrt_start = accept && i_opcode[1];

    bsb_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (i_brush_area),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // Read point, with the optional offset subtraction. A negative value has
    // its top bit set and so fails the unsigned compare against the size.
    logic [COORD_W:0] pt_x;
    logic [COORD_W:0] pt_y;
    logic             pt_in;

    always_comb begin
        pt_x = {r_pos_x[COORD_W-1], r_pos_x};
        pt_y = {r_pos_y[COORD_W-1], r_pos_y};
        if (r_op == OP_READ_SHIFTED) begin
            pt_x = pt_x - {r_offset_x[COORD_W-1], r_offset_x};
            pt_y = pt_y - {r_offset_y[COORD_W-1], r_offset_y};
        end
        pt_in = (pt_x < (COORD_W+1)'(eff_w)) && (pt_y < (COORD_W+1)'(eff_h));
    end

    // Cell address of the read point.
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W:0]   rd_prod;

    assign rd_prod = (ADDR_W+1)'(r_py * eff_w);
    assign rd_addr = rd_prod[ADDR_W-1:0] + ADDR_W'(r_px);

    // Clipping of the brush square to the map.
    logic [HALF_W-1:0]        half;
    logic signed [COORD_W+1:0] lx_f, rx_f, ty_f, by_f;
    logic signed [COORD_W+1:0] lx_c, rx_c, ty_c, by_c;
    logic signed [COORD_W+1:0] w_m1, h_m1;

    always_comb begin
        half = sqrt_root[ROOT_W-1:1];
        w_m1 = $signed({{(COORD_W+2-DIM_W){1'b0}}, eff_w - DIM_W'(1)});
        h_m1 = $signed({{(COORD_W+2-DIM_W){1'b0}}, eff_h - DIM_W'(1)});
        lx_f = $signed({{2{r_pos_x[COORD_W-1]}}, r_pos_x})
               - $signed({{(COORD_W+2-HALF_W){1'b0}}, half});
        rx_f = $signed({{2{r_pos_x[COORD_W-1]}}, r_pos_x})
               + $signed({{(COORD_W+2-HALF_W){1'b0}}, half});
        ty_f = $signed({{2{r_pos_y[COORD_W-1]}}, r_pos_y})
               - $signed({{(COORD_W+2-HALF_W){1'b0}}, half});
        by_f = $signed({{2{r_pos_y[COORD_W-1]}}, r_pos_y})
               + $signed({{(COORD_W+2-HALF_W){1'b0}}, half});
        lx_c = lx_f[COORD_W+1] ? '0 : lx_f;
        ty_c = ty_f[COORD_W+1] ? '0 : ty_f;
        rx_c = (rx_f > w_m1) ? w_m1 : rx_f;
        by_c = (by_f > h_m1) ? h_m1 : by_f;
    end

    // Row span: linear addresses of the first and last cell in the row.
    logic [ADDR_W:0]   row_prod;
    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] row_first;
    logic [ADDR_W-1:0] row_last;

    assign row_prod  = (ADDR_W+1)'(r_cur_y * eff_w);
    assign row_base  = row_prod[ADDR_W-1:0];
    assign row_first = row_base + ADDR_W'(r_lx);
    assign row_last  = row_base + ADDR_W'(r_rx);

    // Bit mask of the row span inside the current memory word.
    logic [BIT_W-1:0]     m_lo;
    logic [BIT_W-1:0]     m_hi;
    logic [WORD_BITS-1:0] mask;
    logic                 last_word;

    always_comb begin
        last_word = (r_word == r_end_a[ADDR_W-1:BIT_W]);
        m_lo = (r_word == r_start_a[ADDR_W-1:BIT_W]) ? r_start_a[BIT_W-1:0] : '0;
        m_hi = last_word ? r_end_a[BIT_W-1:0] : '1;
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i] = (BIT_W'(i) >= m_lo) && (BIT_W'(i) <= m_hi);
        end
    end

    // Memory port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_word;
        mem_wdata = (r_op == OP_SET_SQUARE) ? (r_mem_q | mask) : (r_mem_q & ~mask);
        mem_raddr = r_word;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_RD_REQ: mem_raddr = rd_addr[ADDR_W-1:BIT_W];
            S_WWR:    mem_we    = 1'b1;
            default: ;
        endcase
    end

    // Sequencer: state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + MEM_AW'(1);
                    if (r_clr == MEM_AW'(MEM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= i_opcode[1] ? S_SQRT : S_RD_PT;
                    end
                end
                S_RD_PT:  r_state <= S_RD_REQ;
                S_RD_REQ: r_state <= S_RD_DAT;
                S_RD_DAT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_state <= S_CLIP;
                    end
                end
                S_CLIP: r_state <= S_ROW;
                S_ROW:  r_state <= r_empty ? S_IDLE : S_WRD;
                S_WRD:  r_state <= S_WWR;
                S_WWR: begin
                    if (!last_word) begin
                        r_state <= S_WRD;
                    end else if (r_cur_y == r_by) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_ROW;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= t_opcode'(i_opcode);
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
        end
        if (r_state == S_RD_PT) begin
            r_px    <= pt_x[X_W-1:0];
            r_py    <= pt_y[Y_W-1:0];
            r_inmap <= pt_in;
        end
        if (r_state == S_RD_REQ) begin
            r_bitsel <= rd_addr[BIT_W-1:0];
        end
        if (r_state == S_RD_DAT) begin
            r_bit_value <= r_inmap && r_mem_q[r_bitsel];
        end
        if (r_state == S_CLIP) begin
            r_lx    <= lx_c[X_W-1:0];
            r_rx    <= rx_c[X_W-1:0];
            r_cur_y <= ty_c[Y_W-1:0];
            r_by    <= by_c[Y_W-1:0];
            r_empty <= (lx_c > rx_c) || (ty_c > by_c);
        end
        if (r_state == S_ROW) begin
            r_start_a <= row_first;
            r_end_a   <= row_last;
            r_word    <= row_first[ADDR_W-1:BIT_W];
        end
        if (r_state == S_WWR) begin
            if (!last_word) begin
                r_word <= r_word + MEM_AW'(1);
            end else begin
                r_cur_y <= r_cur_y + Y_W'(1);
            end
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_bit_value = r_bit_value;

endmodule

// ===== tb/bitmap_square_brush_store_test.sv =====
// ----------------------------------------------------------------------------
// bitmap_square_brush_store_test
// Self-checking test of the bit map store with square brush set and clear.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the bit map and its geometry and offset
// registers, updates it on every accepted brush word and predicts the bit of
// every accepted read word. A monitor compares each o_valid strobe with the
// oldest predicted bit. A directed part covers reset contents, clipping and
// the out-of-map cases, then random phases run under several map sizes and
// sender idle rates.
// ----------------------------------------------------------------------------
module bitmap_square_brush_store_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bsb_pkg::*;

    // Margin after the last result or brush before touching the registers
    // or ending the run.
    localparam int SETTLE_CYCLES = 8;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic [1:0]            i_opcode     = '0;
    logic [COORD_W-1:0]    i_pos_x      = '0;
    logic [COORD_W-1:0]    i_pos_y      = '0;
    logic [AREA_W-1:0]     i_brush_area = '0;
    logic                  o_valid;
    logic                  o_bit_value;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    bitmap_square_brush_store dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_brush_area (i_brush_area),
        .o_valid      (o_valid),
        .o_bit_value  (o_bit_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Predicted map contents and register copies, as they stand after reset.
    bit       map_bits [CELL_COUNT];
    bit [8:0] width_reg  = 9'd256;
    bit [8:0] height_reg = 9'd256;
    int       offset_x   = 0;
    int       offset_y   = 0;

    // Bits that read words are still owed, oldest first.
    bit       expected_bits [$];
    int       error_count = 0;

    // Idle rate of the sender in percent, set per phase.
    int       sender_idle_pct = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run; the slowest legal run is far shorter than this.
    initial begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // ---------------------------------------------------------------- model

    // Register values of 0 act as 1 and values above the maximum act as it.
    function automatic int used_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int used_height();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    function automatic bit point_in_map(int x, int y);
        return x >= 0 && y >= 0 && x < used_width() && y < used_height();
    endfunction

    // Cells are stored row-major at the current width, so a geometry change
    // re-maps what is already in the store.
    function automatic bit read_point(int x, int y);
        if (!point_in_map(x, y)) return 1'b0;
        return map_bits[y * used_width() + x];
    endfunction

    function automatic void put_point(int x, int y, bit val);
        if (point_in_map(x, y)) map_bits[y * used_width() + x] = val;
    endfunction

    function automatic int floor_root(int area);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= area) r++;
        return r;
    endfunction

    function automatic void paint_square(int x, int y, int area, bit val);
        int half;
        int lx;
        int rx;
        int ty;
        int by;
        if (area <= 1) begin
            put_point(x, y, val);
            return;
        end
        half = floor_root(area) / 2;
        lx = (x - half < 0) ? 0 : x - half;
        rx = (x + half > used_width() - 1) ? used_width() - 1 : x + half;
        ty = (y - half < 0) ? 0 : y - half;
        by = (y + half > used_height() - 1) ? used_height() - 1 : y + half;
        for (int j = ty; j <= by; j++)
            for (int i = lx; i <= rx; i++)
                put_point(i, j, val);
    endfunction

    // ------------------------------------------------------------- drivers

    // Sends one command word and waits for the edge that takes it. Called and
    // left at a rising edge; start stays high when no idle gap follows, so the
    // next word can be taken back to back.
    task automatic send_word(input t_opcode op, input int x, input int y, input int area);
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        sx = x[COORD_W-1:0];
        sy = y[COORD_W-1:0];
        i_opcode     <= op;
        i_pos_x      <= sx;
        i_pos_y      <= sy;
        i_brush_area <= area[AREA_W-1:0];
        start        <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        case (op)
            OP_READ_DIRECT:  expected_bits.push_back(read_point(int'(sx), int'(sy)));
            OP_READ_SHIFTED: expected_bits.push_back(
                                 read_point(int'(sx) - offset_x, int'(sy) - offset_y));
            OP_SET_SQUARE:   paint_square(int'(sx), int'(sy), int'(area[AREA_W-1:0]), 1'b1);
            default:         paint_square(int'(sx), int'(sy), int'(area[AREA_W-1:0]), 1'b0);
        endcase
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Drops start and waits until no read is owed and no brush is running.
    // Brushes give no result, so busy is the only sign of one in flight.
    task automatic wait_for_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (busy !== 1'b0 || expected_bits.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        wait_for_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_MAP_WIDTH:  width_reg  = data[8:0];
            CFG_MAP_HEIGHT: height_reg = data[8:0];
            CFG_OFFSET_X:   offset_x   = int'($signed(data));
            default:        offset_y   = int'($signed(data));
        endcase
    endtask

    // ------------------------------------------------------------- monitor

    // The result is sampled at the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_bits.size() == 0) begin
                report_mismatch($sformatf("bit word %0b with no read outstanding",
                                          o_bit_value));
            end else begin
                want = expected_bits.pop_front();
                if (o_bit_value !== want)
                    report_mismatch($sformatf("bit_value got %b want %0b",
                                              o_bit_value, want));
            end
        end
    end

    // --------------------------------------------------------------- tests

    // After reset the whole map reads zero, including its far corner.
    task automatic test_reset_clear();
        send_word(OP_READ_DIRECT, 0, 0, 0);
        send_word(OP_READ_DIRECT, 255, 255, 0);
        send_word(OP_READ_SHIFTED, 128, 7, 16'hFFFF);
    endtask

    // Single cells, clipped squares and writes that fall off the map, on the
    // full 256 by 256 map with zero offsets.
    task automatic test_point_and_brush();
        send_word(OP_SET_SQUARE, 0, 0, 0);              // area 0: one cell
        send_word(OP_READ_DIRECT, 0, 0, 0);
        send_word(OP_SET_SQUARE, 255, 255, 1);          // area 1: one cell
        send_word(OP_READ_SHIFTED, 255, 255, 0);
        // Single-cell writes outside the map must leave the store alone.
        send_word(OP_SET_SQUARE, -1, 3, 1);
        send_word(OP_SET_SQUARE, 32767, -32768, 0);
        send_word(OP_SET_SQUARE, 256, 0, 1);
        send_word(OP_READ_DIRECT, -32768, 32767, 0);
        send_word(OP_READ_DIRECT, 256, 0, 0);
        // Area 3 has half-side 0 but still goes through clipping.
        send_word(OP_SET_SQUARE, -1, 0, 3);
        send_word(OP_READ_DIRECT, 0, 1, 0);
        // Largest area: half-side 127 around the center.
        send_word(OP_SET_SQUARE, 128, 128, 65535);
        send_word(OP_READ_DIRECT, 1, 1, 0);
        send_word(OP_CLEAR_SQUARE, 1, 1, 9);
        send_word(OP_READ_DIRECT, 2, 2, 0);
        send_word(OP_READ_DIRECT, 3, 3, 0);
        // A square wholly off the map clips to nothing.
        send_word(OP_SET_SQUARE, -100, -100, 100);
        send_word(OP_CLEAR_SQUARE, 255, 0, 4);
        send_word(OP_READ_SHIFTED, 254, 1, 0);
        send_word(OP_CLEAR_SQUARE, 0, 0, 65535);
        send_word(OP_READ_DIRECT, 127, 127, 0);
    endtask

    // Out-of-range geometry values, register bits above the 9-bit width, and
    // offsets at both ends of their range.
    task automatic test_geometry_registers();
        cfg_write(CFG_MAP_WIDTH, 16'h0000);             // acts as 1
        cfg_write(CFG_MAP_HEIGHT, 16'h0200);            // masks to 0, acts as 1
        send_word(OP_SET_SQUARE, 0, 0, 400);
        send_word(OP_READ_DIRECT, 0, 0, 0);
        send_word(OP_READ_DIRECT, 1, 0, 0);
        cfg_write(CFG_MAP_WIDTH, 16'hFFFF);             // masks to 511, acts as 256
        cfg_write(CFG_MAP_HEIGHT, 16'd300);
        cfg_write(CFG_OFFSET_X, 16'h8000);
        cfg_write(CFG_OFFSET_Y, 16'h7FFF);
        send_word(OP_READ_SHIFTED, -32768 + 5, 32767, 0);
        send_word(OP_READ_SHIFTED, 32767, -32768, 0);
        cfg_write(CFG_OFFSET_X, 16'h7FFF);
        cfg_write(CFG_OFFSET_Y, 16'h8000);
        send_word(OP_READ_SHIFTED, 32767, -32768 + 200, 0);
    endtask

    // Random traffic on a freshly chosen geometry. Most coordinates land on
    // or just around the map so reads see painted cells; the rest span the
    // whole 16-bit range. Areas are mostly small, with a few of any size.
    task automatic test_random_traffic(input int count, input int idle_pct, input int dim_lo,
                                       input int dim_hi, input int off_span);
        int      pick;
        int      x;
        int      y;
        int      area;
        t_opcode op;
        sender_idle_pct = 0;
        cfg_write(CFG_MAP_WIDTH, 16'($urandom_range(dim_lo, dim_hi)));
        cfg_write(CFG_MAP_HEIGHT, 16'($urandom_range(dim_lo, dim_hi)));
        cfg_write(CFG_OFFSET_X, 16'(int'($urandom_range(0, 2 * off_span)) - off_span));
        cfg_write(CFG_OFFSET_Y, 16'(int'($urandom_range(0, 2 * off_span)) - off_span));
        sender_idle_pct = idle_pct;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 35)      op = OP_READ_DIRECT;
            else if (pick < 55) op = OP_READ_SHIFTED;
            else if (pick < 85) op = OP_SET_SQUARE;
            else                op = OP_CLEAR_SQUARE;
            if ($urandom_range(99) < 85) begin
                x = int'($urandom_range(0, used_width() + 5)) - 3;
                y = int'($urandom_range(0, used_height() + 5)) - 3;
                if (op == OP_READ_SHIFTED) begin
                    x += offset_x;
                    y += offset_y;
                end
            end else begin
                x = int'($signed(16'($urandom)));
                y = int'($signed(16'($urandom)));
            end
            pick = $urandom_range(99);
            if (pick < 40)      area = $urandom_range(0, 4);
            else if (pick < 80) area = $urandom_range(5, 200);
            else if (pick < 95) area = $urandom_range(201, 4095);
            else                area = $urandom_range(0, 65535);
            send_word(op, x, y, area);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_clear();
        test_point_and_brush();
        test_geometry_registers();
        test_random_traffic(120, 0, 8, 48, 16);
        test_random_traffic(120, 55, 1, 6, 8);
        test_random_traffic(120, 37, 16, 64, 40);
        test_random_traffic(90, 0, 256, 256, 300);

        wait_for_idle();
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bsb_pkg.sv
rtl/bsb_isqrt.sv
rtl/bitmap_square_brush_store.sv
tb/bitmap_square_brush_store_test.sv
